// ----- src/lmfb_pkg.sv -----
// Shared types, codes and constants of the LED matrix frame writer.
`default_nettype none
package lmfb_pkg;

  localparam int MAX_MODULES_DEF = 8;
  localparam int BYTES_PER_MODULE_MAX_DEF = 48;

  localparam int LADDR_W = 10;
  localparam int MIU_W = 5;
  localparam int BCNT_W = 6;
  localparam int IN_DATA_W = 24;
  localparam int IN_USER_W = 2;
  localparam int OUT_DATA_W = 8;
  localparam int OUT_USER_W = 3;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W = 4;

  localparam logic [1:0] ACT_PLOT = 2'd0;
  localparam logic [1:0] ACT_FLUSH = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;
  localparam logic [1:0] ACT_FILL = 2'd3;

  localparam logic [1:0] CMD_PLOT = 2'd0;
  localparam logic [1:0] CMD_FLUSH = 2'd1;
  localparam logic [1:0] CMD_FILL = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] REG_PANEL_TYPE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MODULE_COUNT = 2'd1;

  localparam logic PANEL_24X16 = 1'b0;
  localparam logic PANEL_32X8 = 1'b1;

  localparam logic [BCNT_W-1:0] BYTES_24X16 = 6'd48;
  localparam logic [BCNT_W-1:0] BYTES_32X8 = 6'd32;

  localparam logic [7:0] FRAME_HEADER = 8'd160;

  typedef struct packed {
    logic [1:0] op;
    logic [LADDR_W-1:0] addr;
    logic [7:0] mask;
    logic value;
    logic [2:0] module_sel;
    logic panel;
  } cmd_t;

endpackage
`default_nettype wire

// ----- src/lmfb_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none
module lmfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 384
) (
  input wire logic clk,
  input wire logic we,
  input wire logic [$clog2(DEPTH)-1:0] waddr,
  input wire logic [WIDTH-1:0] wdata,
  input wire logic re,
  input wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- src/lmfb_front.sv -----
// Front end: configuration registers, input acceptance and command classification.
`default_nettype none
module lmfb_front #(
  parameter int MAX_MODULES = 8,
  parameter int STORE_DEPTH = 384
) (
  input wire logic clk,
  input wire logic rst,
  input wire logic cfg_valid,
  output logic cfg_ready,
  input wire logic [lmfb_pkg::CFG_INDEX_W-1:0] cfg_index,
  input wire logic [lmfb_pkg::CFG_DATA_W-1:0] cfg_data,
  input wire logic s_axis_tvalid,
  output logic s_axis_tready,
  input wire logic [lmfb_pkg::IN_DATA_W-1:0] s_axis_tdata,
  input wire logic [lmfb_pkg::IN_USER_W-1:0] s_axis_tuser,
  input wire logic init_done,
  output logic push_valid,
  input wire logic push_ready,
  output lmfb_pkg::cmd_t push_cmd
);
  import lmfb_pkg::*;

  logic panel_type;
  logic [CFG_DATA_W-1:0] module_count;

  logic [9:0] pos_x;
  logic [5:0] pos_y;
  logic pixel_on;
  logic [2:0] module_index;
  logic [MIU_W-1:0] miu;
  logic [LADDR_W-1:0] width_lim;
  logic [LADDR_W-1:0] plot_idx;
  logic [LADDR_W-1:0] flush_base;
  logic [LADDR_W-1:0] fill_n;
  logic [LADDR_W-1:0] fill_end;
  logic x_ok, y_ok, idx_ok, flush_ok, keep;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      panel_type <= PANEL_24X16;
      module_count <= 4'd1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_PANEL_TYPE: panel_type <= cfg_data[0];
        REG_MODULE_COUNT: module_count <= cfg_data;
        default: ;
      endcase
    end
  end

  assign pos_x = s_axis_tdata[9:0];
  assign pos_y = s_axis_tdata[15:10];
  assign pixel_on = s_axis_tdata[16];
  assign module_index = s_axis_tdata[19:17];

  always_comb begin
    if (module_count == '0) begin
      miu = 5'd1;
    end else if ({1'b0, module_count} > 5'(MAX_MODULES)) begin
      miu = 5'(MAX_MODULES);
    end else begin
      miu = {1'b0, module_count};
    end
  end

  always_comb begin
    if (panel_type == PANEL_32X8) begin
      width_lim = {miu, 5'b0};
      y_ok = !pos_y[5] && (pos_y[4:3] == 2'b00);
      plot_idx = {1'b0, pos_x[8:0]};
      flush_base = {2'b0, module_index, 5'b0};
      fill_n = {miu, 5'b0};
    end else begin
      width_lim = {1'b0, miu, 4'b0} + {2'b0, miu, 3'b0};
      y_ok = !pos_y[5] && !pos_y[4];
      plot_idx = {pos_x[8:0], pos_y[3]};
      flush_base = {2'b0, module_index, 5'b0} + {3'b0, module_index, 4'b0};
      fill_n = {miu, 5'b0} + {1'b0, miu, 4'b0};
    end
  end

  assign x_ok = !pos_x[9] && ({1'b0, pos_x[8:0]} < width_lim);
  assign idx_ok = plot_idx < 10'(STORE_DEPTH);
  assign flush_ok = {2'b0, module_index} < miu;
  assign fill_end = (fill_n > 10'(STORE_DEPTH)) ? 10'(STORE_DEPTH) : fill_n;

  always_comb begin
    push_cmd.mask = 8'h80 >> pos_y[2:0];
    push_cmd.module_sel = module_index;
    push_cmd.panel = panel_type;
    unique case (s_axis_tuser)
      ACT_PLOT: begin
        keep = x_ok && y_ok && idx_ok;
        push_cmd.op = CMD_PLOT;
        push_cmd.addr = plot_idx;
        push_cmd.value = pixel_on;
      end
      ACT_FLUSH: begin
        keep = flush_ok;
        push_cmd.op = CMD_FLUSH;
        push_cmd.addr = flush_base;
        push_cmd.value = 1'b0;
      end
      ACT_CLEAR: begin
        keep = 1'b1;
        push_cmd.op = CMD_FILL;
        push_cmd.addr = fill_end;
        push_cmd.value = 1'b0;
      end
      ACT_FILL: begin
        keep = 1'b1;
        push_cmd.op = CMD_FILL;
        push_cmd.addr = fill_end;
        push_cmd.value = 1'b1;
      end
      default: begin
        keep = 1'b0;
        push_cmd.op = CMD_PLOT;
        push_cmd.addr = plot_idx;
        push_cmd.value = 1'b0;
      end
    endcase
  end

  assign s_axis_tready = init_done && push_ready;
  assign push_valid = s_axis_tvalid && init_done && keep;

endmodule
`default_nettype wire

// ----- src/lmfb_queue.sv -----
// Two-entry command queue between the front end and the store engine.
`default_nettype none
module lmfb_queue (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  output logic in_ready,
  input wire lmfb_pkg::cmd_t in_cmd,
  output logic out_valid,
  input wire logic out_ready,
  output lmfb_pkg::cmd_t out_cmd
);
  import lmfb_pkg::*;

  cmd_t entry [2];
  logic wr_ptr;
  logic rd_ptr;
  logic [1:0] count;
  logic push, pop;

  assign in_ready = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_cmd = entry[rd_ptr];
  assign push = in_valid && in_ready;
  assign pop = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= in_cmd;
    end
  end

endmodule
`default_nettype wire

// ----- src/lmfb_back.sv -----
// Store engine: clearing pass, pixel updates, fills and frame output over the pixel store.
`default_nettype none
module lmfb_back #(
  parameter int STORE_DEPTH = 384
) (
  input wire logic clk,
  input wire logic rst,
  input wire logic cmd_valid,
  output logic cmd_ready,
  input wire lmfb_pkg::cmd_t cmd,
  output logic init_done,
  output logic m_axis_tvalid,
  input wire logic m_axis_tready,
  output logic [lmfb_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  output logic [lmfb_pkg::OUT_USER_W-1:0] m_axis_tuser,
  output logic m_axis_tlast
);
  import lmfb_pkg::*;

  localparam int RAM_AW = $clog2(STORE_DEPTH);

  localparam logic [1:0] ST_SWEEP = 2'd0;
  localparam logic [1:0] ST_IDLE = 2'd1;
  localparam logic [1:0] ST_PLOT = 2'd2;
  localparam logic [1:0] ST_FLUSH = 2'd3;

  logic [1:0] state;
  logic [LADDR_W-1:0] sweep_cnt;
  logic [LADDR_W-1:0] sweep_end;
  logic fill_val;
  logic [LADDR_W-1:0] cur_addr;
  logic [7:0] cur_mask;
  logic cur_on;
  logic [2:0] cur_mod;
  logic cur_panel;
  logic [BCNT_W-1:0] k;
  logic [BCNT_W-1:0] rd_cnt;
  logic rd_pend;
  logic rd_zero;
  logic [7:0] prev;
  logic [7:0] s0;
  logic [7:0] s1;

  logic ram_we, ram_re;
  logic [RAM_AW-1:0] ram_waddr, ram_raddr;
  logic [7:0] ram_wdata, ram_rdata;

  logic [BCNT_W-1:0] nbytes;
  logic [7:0] rd_byte;
  logic [LADDR_W-1:0] flush_addr;
  logic addr_oob;
  logic slot_free, in_flush;
  logic emit_hdr, emit_data, emit_tail1, emit_tail2, emit, issue;
  logic [7:0] emit_byte;

  assign nbytes = (cur_panel == PANEL_32X8) ? BYTES_32X8 : BYTES_24X16;
  assign rd_byte = rd_zero ? 8'd0 : ram_rdata;
  assign flush_addr = cur_addr + {4'b0, rd_cnt};
  assign addr_oob = flush_addr >= 10'(STORE_DEPTH);
  assign slot_free = !m_axis_tvalid || m_axis_tready;
  assign in_flush = (state == ST_FLUSH);

  assign emit_hdr = in_flush && (k == '0) && slot_free;
  assign emit_data = in_flush && (k != '0) && (k <= nbytes) && rd_pend && slot_free;
  assign emit_tail1 = in_flush && (k == nbytes + 6'd1) && slot_free;
  assign emit_tail2 = in_flush && (k == nbytes + 6'd2) && slot_free;
  assign emit = emit_hdr || emit_data || emit_tail1 || emit_tail2;
  assign issue = in_flush && (rd_cnt < nbytes) && (!rd_pend || emit_data);

  always_comb begin
    priority if (emit_hdr) begin
      emit_byte = FRAME_HEADER;
    end else if (emit_data) begin
      emit_byte = {prev[1:0], rd_byte[7:2]};
    end else if (emit_tail1) begin
      emit_byte = {prev[1:0], s0[7:2]};
    end else begin
      emit_byte = {s0[1:0], s1[7:2]};
    end
  end

  assign cmd_ready = (state == ST_IDLE);

  assign ram_we = (state == ST_SWEEP) || (state == ST_PLOT);
  assign ram_waddr = (state == ST_SWEEP) ? sweep_cnt[RAM_AW-1:0] : cur_addr[RAM_AW-1:0];
  assign ram_wdata = (state == ST_SWEEP) ? {8{fill_val}} :
                     (cur_on ? (ram_rdata | cur_mask) : (ram_rdata & ~cur_mask));
  assign ram_re = ((state == ST_IDLE) && cmd_valid && (cmd.op == CMD_PLOT)) ||
                  (issue && !addr_oob);
  assign ram_raddr = (state == ST_IDLE) ? cmd.addr[RAM_AW-1:0] : flush_addr[RAM_AW-1:0];

  lmfb_ram #(
    .WIDTH(8),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk(clk),
    .we(ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re(ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_SWEEP;
      sweep_cnt <= '0;
      sweep_end <= 10'(STORE_DEPTH);
      fill_val <= 1'b0;
      init_done <= 1'b0;
      rd_pend <= 1'b0;
      k <= '0;
      rd_cnt <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      unique case (state)
        ST_SWEEP: begin
          sweep_cnt <= sweep_cnt + 10'd1;
          if (sweep_cnt == sweep_end - 10'd1) begin
            state <= ST_IDLE;
            init_done <= 1'b1;
          end
        end
        ST_IDLE: begin
          if (cmd_valid) begin
            unique case (cmd.op)
              CMD_PLOT: state <= ST_PLOT;
              CMD_FLUSH: begin
                k <= '0;
                rd_cnt <= '0;
                rd_pend <= 1'b0;
                state <= ST_FLUSH;
              end
              CMD_FILL: begin
                sweep_cnt <= '0;
                sweep_end <= cmd.addr;
                fill_val <= cmd.value;
                state <= ST_SWEEP;
              end
              default: ;
            endcase
          end
        end
        ST_PLOT: state <= ST_IDLE;
        ST_FLUSH: begin
          if (issue) begin
            rd_cnt <= rd_cnt + 6'd1;
            rd_pend <= 1'b1;
          end else if (emit_data) begin
            rd_pend <= 1'b0;
          end
          if (emit) begin
            k <= k + 6'd1;
          end
          if (emit_tail2) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase

      if (emit) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_ready && cmd_valid) begin
      cur_addr <= cmd.addr;
      cur_mask <= cmd.mask;
      cur_on <= cmd.value;
      cur_mod <= cmd.module_sel;
      cur_panel <= cmd.panel;
      prev <= 8'd0;
    end
    if (issue) begin
      rd_zero <= addr_oob;
    end
    if (emit_data) begin
      prev <= rd_byte;
      if (k == 6'd1) begin
        s0 <= rd_byte;
      end
      if (k == 6'd2) begin
        s1 <= rd_byte;
      end
    end
    if (emit) begin
      m_axis_tdata <= emit_byte;
      m_axis_tuser <= cur_mod;
      m_axis_tlast <= emit_tail2;
    end
  end

endmodule
`default_nettype wire

// ----- src/led_matrix_framebuffer_frame_writer.sv -----
// Top level of the LED matrix pixel store and module frame writer.
//
// The block holds a pixel store of MAX_MODULES * BYTES_PER_MODULE_MAX bytes in
// one memory. After reset it runs a clearing pass over all of those bytes (384
// by default) during which no input item is taken; configuration writes are
// taken at all times. Input items are classified at once and queued in a
// two-entry command queue, so the input side keeps moving while the store
// engine works and the queue has room. Items that change nothing are taken
// without being queued. A plot reads one store byte in the idle state and
// writes it back in the plot state, through the single memory port pair.
// Clear and fill start from the idle state and then write each byte in use,
// bytes per module times modules in use. A flush starts from the idle state
// and emits its B + 3 frame bytes at one byte per cycle, B being 48 or 32,
// as long as the output is taken; the output register lets the next byte be
// prepared while the current one waits.
`default_nettype none
module led_matrix_framebuffer_frame_writer #(
  parameter int MAX_MODULES = lmfb_pkg::MAX_MODULES_DEF,
  parameter int BYTES_PER_MODULE_MAX = lmfb_pkg::BYTES_PER_MODULE_MAX_DEF
) (
  input wire logic clk,
  input wire logic rst,
  input wire logic cfg_valid,
  output logic cfg_ready,
  input wire logic [lmfb_pkg::CFG_INDEX_W-1:0] cfg_index,
  input wire logic [lmfb_pkg::CFG_DATA_W-1:0] cfg_data,
  input wire logic s_axis_tvalid,
  output logic s_axis_tready,
  // pos_x [9:0], pos_y [15:10], pixel_on [16], module_index [19:17], zero [23:20]
  input wire logic [lmfb_pkg::IN_DATA_W-1:0] s_axis_tdata,
  // action [1:0]
  input wire logic [lmfb_pkg::IN_USER_W-1:0] s_axis_tuser,
  output logic m_axis_tvalid,
  input wire logic m_axis_tready,
  // frame_byte [7:0]
  output logic [lmfb_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // module_select [2:0]
  output logic [lmfb_pkg::OUT_USER_W-1:0] m_axis_tuser,
  output logic m_axis_tlast
);
  import lmfb_pkg::*;

  localparam int STORE_DEPTH = MAX_MODULES * BYTES_PER_MODULE_MAX;

  logic init_done;
  logic push_valid, push_ready;
  cmd_t push_cmd;
  logic cmd_valid, cmd_ready;
  cmd_t cmd;

  lmfb_front #(
    .MAX_MODULES(MAX_MODULES),
    .STORE_DEPTH(STORE_DEPTH)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .init_done(init_done),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_cmd(push_cmd)
  );

  lmfb_queue u_queue (
    .clk(clk),
    .rst(rst),
    .in_valid(push_valid),
    .in_ready(push_ready),
    .in_cmd(push_cmd),
    .out_valid(cmd_valid),
    .out_ready(cmd_ready),
    .out_cmd(cmd)
  );

  lmfb_back #(
    .STORE_DEPTH(STORE_DEPTH)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd(cmd),
    .init_done(init_done),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast)
  );

  // No request is taken and no frame byte is offered before the clearing pass ends.
  a_init_gate: assert property (@(posedge clk) disable iff (rst)
    !init_done |-> (!s_axis_tready && !m_axis_tvalid))
    else $error("activity before the store clearing pass finished");

  // The clearing pass runs once after reset and is never repeated.
  a_init_stays: assert property (@(posedge clk) disable iff (rst)
    init_done |=> init_done)
    else $error("store clearing pass restarted without reset");

  // A queued command is only handed to the store engine after the clearing pass.
  a_cmd_after_init: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && cmd_ready) |-> init_done)
    else $error("command executed before the store was cleared");

endmodule
`default_nettype wire
